>>> design/dm1_fault_report_framer_assert.svh
// Assertion macros for the DM1 fault report framer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef DM1_FAULT_REPORT_FRAMER_ASSERT_SVH
`define DM1_FAULT_REPORT_FRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define DM1FRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dm1 framer: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define DM1FRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dm1 framer: next-cycle check failed");

`endif

>>> design/dm1frm_pkg.sv
// Shared types, constants and fault table for the DM1 fault report framer.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dm1frm_pkg;

  localparam int FIXED_ENTRIES     = 24;
  localparam int TABLE_ENTRIES_DEF = 24;

  // Frame kinds on the result channel
  localparam logic [1:0] KIND_SINGLE   = 2'd0;
  localparam logic [1:0] KIND_ANNOUNCE = 2'd1;
  localparam logic [1:0] KIND_DATA     = 2'd2;

  // Fixed byte values
  localparam logic [15:0] SPN_RED_A  = 16'h1388;
  localparam logic [15:0] SPN_RED_B  = 16'h1389;
  localparam logic [7:0]  LAMP_RED   = 8'hD3;
  localparam logic [7:0]  LAMP_AMBER = 8'hC7;
  localparam logic [7:0]  LAMP_NONE  = 8'hC3;
  localparam logic [7:0]  BAM_CTRL   = 8'h20;
  localparam logic [7:0]  PGN_LO     = 8'hCA;
  localparam logic [7:0]  PGN_MID    = 8'hFE;
  localparam logic [7:0]  PAD_BYTE   = 8'hFF;
  localparam logic [7:0]  OCC_ONE    = 8'h01;
  localparam logic [4:0]  FMI_MASK   = 5'h1F;
  localparam logic [2:0]  SPN_TOP_MASK = 3'h7;

  // Where a data frame byte comes from
  typedef enum logic [1:0] {
    SRC_LAMP = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_MEM  = 2'd2
  } byte_src_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_HEAD = 5'b00100,
    ST_FILL = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  // SPN of each table entry
  function automatic logic [15:0] spn_of(input logic [4:0] e);
    logic [15:0] s;
    unique case (e)
      5'd0:  s = 16'h1388;
      5'd1:  s = 16'h138A;
      5'd2:  s = 16'h138D;
      5'd3:  s = 16'h138E;
      5'd4:  s = 16'h1390;
      5'd5:  s = 16'h1391;
      5'd6:  s = 16'h1393;
      5'd7:  s = 16'h1394;
      5'd8:  s = 16'h13BA;
      5'd9:  s = 16'h13BB;
      5'd10: s = 16'h13BC;
      5'd11: s = 16'h13BD;
      5'd12: s = 16'h13BE;
      5'd13: s = 16'h13BE;
      5'd14: s = 16'h13BE;
      5'd15: s = 16'h13BF;
      5'd16: s = 16'h13BF;
      5'd17: s = 16'h13BF;
      5'd18: s = 16'h13C0;
      5'd19: s = 16'h13C0;
      5'd20: s = 16'h13C0;
      5'd21: s = 16'h13C1;
      5'd22: s = 16'h13C1;
      5'd23: s = 16'h13C1;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // Failure mode of each table entry
  function automatic logic [4:0] fmi_of(input logic [4:0] e);
    logic [4:0] f;
    unique case (e)
      5'd0:  f = 5'h9;
      5'd1:  f = 5'hD;
      5'd2:  f = 5'h5;
      5'd3:  f = 5'h6;
      5'd4:  f = 5'h5;
      5'd5:  f = 5'h6;
      5'd6:  f = 5'h5;
      5'd7:  f = 5'h6;
      5'd8:  f = 5'h6;
      5'd9:  f = 5'h2;
      5'd10: f = 5'h6;
      5'd11: f = 5'h6;
      5'd12: f = 5'h6;
      5'd13: f = 5'h9;
      5'd14: f = 5'h2;
      5'd15: f = 5'h6;
      5'd16: f = 5'h9;
      5'd17: f = 5'h2;
      5'd18: f = 5'h6;
      5'd19: f = 5'h9;
      5'd20: f = 5'h2;
      5'd21: f = 5'h6;
      5'd22: f = 5'h9;
      5'd23: f = 5'h2;
      default: f = 5'h0;
    endcase
    return f;
  endfunction

  // Link faults light the red stop lamp
  function automatic logic is_red(input logic [4:0] e);
    logic [15:0] s;
    s = spn_of(e);
    return (s == SPN_RED_A) || (s == SPN_RED_B);
  endfunction

  // Four report bytes of one entry, byte 0 in the low lane:
  // SPN low, SPN middle, SPN top bits with FMI, occurrence count
  function automatic logic [31:0] fault_record(input logic [4:0] e);
    logic [15:0] s;
    logic [7:0]  hi;
    s  = spn_of(e);
    // SPN values are 16 bits wide, so the top field is always zero
    hi = {3'b000 & SPN_TOP_MASK, fmi_of(e) & FMI_MASK};
    return {OCC_ONE, hi, s[15:8], s[7:0]};
  endfunction

  // ceil(total / 7) for total up to 98, by reciprocal multiply
  function automatic logic [3:0] bam_packets(input logic [6:0] total);
    logic [6:0]  biased;
    logic [14:0] prod;
    biased = total + 7'd6;
    prod   = 15'(biased) * 15'd147;
    return prod[13:10];
  endfunction

endpackage

`default_nettype wire

>>> design/dm1frm_if.sv
// Valid/ready channel interfaces for the DM1 fault report framer.
// Depends on nothing but the port widths of the fault mask and frame bytes.
`timescale 1ns / 1ps
`default_nettype none

interface dm1frm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] fault_mask;

  modport source (output valid, output fault_mask, input ready);
  modport sink   (input valid, input fault_mask, output ready);
endinterface

interface dm1frm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;
  logic       last_frame;

  modport source (output valid, output frame_kind, output byte0, output byte1,
                  output byte2, output byte3, output byte4, output byte5,
                  output byte6, output byte7, output last_frame, input ready);
  modport sink   (input valid, input frame_kind, input byte0, input byte1,
                  input byte2, input byte3, input byte4, input byte5,
                  input byte6, input byte7, input last_frame, output ready);
endinterface

`default_nettype wire

>>> design/dm1_fault_report_framer.sv
// DM1 fault report framer: fault mask in, 8-byte CAN frames out.
// Depends on dm1frm_pkg, dm1frm_if and dm1_fault_report_framer_assert.svh.
//
//   channel   | direction | payload                              | handshake
//   in_chan   | in        | fault_mask[31:0]                     | valid/ready
//   out_chan  | out       | frame_kind, byte0..byte7, last_frame | valid/ready
//
// The idle state takes a mask; the scan then reads one table entry per cycle
// (LIVE, 24 by default) and writes each listed fault's record into the report
// memory; the head state builds the first frame, and every frame is held in the
// send state until it transfers. A data frame is built in the fill state: seven
// word reads plus the last capture.
// Reset is synchronous and clears the control registers only; memory is not swept.
// A stalled result holds the sequencer in the send state; no mask is taken
// until the last frame of a run transfers.
`timescale 1ns / 1ps
`default_nettype none

`include "dm1_fault_report_framer_assert.svh"

module dm1_fault_report_framer
  import dm1frm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  dm1frm_in_if.sink      in_chan,
  dm1frm_out_if.source   out_chan
);

  localparam int LIVE = (TABLE_ENTRIES > FIXED_ENTRIES) ? FIXED_ENTRIES : TABLE_ENTRIES;
  localparam int WAW  = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam logic [4:0] SCAN_LAST = 5'(LIVE - 1);

  // Report memory: one 4-byte record per listed fault
  logic [31:0] mem [LIVE];
  logic [31:0] mem_q_r;
  logic            mem_we;
  logic [WAW-1:0]  mem_wa;
  logic [WAW-1:0]  rd_addr;

  state_t      state_r, state_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [4:0]  scan_r, scan_nxt;
  logic [4:0]  count_r, count_nxt;     // listed fault count
  logic [4:0]  first_r, first_nxt;
  logic        red_r, red_nxt;
  logic [6:0]  total_r, total_nxt;
  logic [6:0]  base_r, base_nxt;
  logic [3:0]  seq_r, seq_nxt;         // frame sequence
  logic [2:0]  j_r, j_nxt;

  // Read pipeline stage
  logic        rd_vld_r, rd_vld_nxt;
  byte_src_t   rd_src_r, rd_src_nxt;
  logic [1:0]  rd_sel_r, rd_sel_nxt;
  logic [2:0]  rd_pos_r, rd_pos_nxt;

  // Output register
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_b_r [8];
  logic [7:0]  out_b_nxt [8];
  logic        out_last_r, out_last_nxt;

  logic        hit;
  logic [6:0]  idx;
  logic [6:0]  off;
  logic [6:0]  total_w;
  logic [7:0]  byte_w;
  logic [7:0]  mem_byte;
  logic [31:0] rec_first;
  logic [6:0]  base_end;

  assign hit      = mask_r[scan_r];
  assign idx      = base_r + {4'b0000, j_r};
  assign off      = idx - 7'd2;
  assign total_w  = {count_r, 2'b00} + 7'd2;
  assign rec_first = fault_record(first_r);
  assign base_end = base_r + 7'd7;

  assign mem_we = (state_r == ST_SCAN) && hit;
  assign mem_wa = WAW'(count_r);

  // Pick the byte lane of the registered word
  always_comb begin
    unique case (rd_sel_r)
      2'd0: mem_byte = mem_q_r[7:0];
      2'd1: mem_byte = mem_q_r[15:8];
      2'd2: mem_byte = mem_q_r[23:16];
      2'd3: mem_byte = mem_q_r[31:24];
      default: mem_byte = PAD_BYTE;
    endcase
  end

  always_comb begin
    unique case (rd_src_r)
      SRC_LAMP: byte_w = red_r ? LAMP_RED : LAMP_AMBER;
      SRC_MEM:  byte_w = mem_byte;
      default:  byte_w = PAD_BYTE;
    endcase
  end

  // Classify the message byte at idx and address the memory
  always_comb begin
    rd_sel_nxt = off[1:0];
    rd_pos_nxt = j_r;
    rd_vld_nxt = (state_r == ST_FILL) && (j_r != 3'd7);
    rd_addr    = '0;
    priority if (idx == 7'd0) begin
      rd_src_nxt = SRC_LAMP;
    end else if (idx == 7'd1 || idx >= total_r) begin
      rd_src_nxt = SRC_PAD;
    end else begin
      rd_src_nxt = SRC_MEM;
      rd_addr    = WAW'(off[6:2]);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    mask_nxt     = mask_r;
    scan_nxt     = scan_r;
    count_nxt    = count_r;
    first_nxt    = first_r;
    red_nxt      = red_r;
    total_nxt    = total_r;
    base_nxt     = base_r;
    seq_nxt      = seq_r;
    j_nxt        = j_r;
    out_kind_nxt = out_kind_r;
    out_last_nxt = out_last_r;
    for (int b = 0; b < 8; b++) begin
      out_b_nxt[b] = out_b_r[b];
    end

    unique case (state_r)
      ST_IDLE: begin
        // Take a mask; a zero mask gives nothing
        if (in_chan.valid && in_chan.fault_mask != 32'd0) begin
          mask_nxt  = in_chan.fault_mask;
          scan_nxt  = '0;
          count_nxt = '0;
          first_nxt = '0;
          red_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Count listed faults; the record write happens alongside
        if (hit) begin
          count_nxt = count_r + 5'd1;
          red_nxt   = red_r | is_red(scan_r);
          if (count_r == 5'd0) begin
            first_nxt = scan_r;
          end
        end
        scan_nxt = scan_r + 5'd1;
        if (scan_r == SCAN_LAST) begin
          state_nxt = ST_HEAD;
        end
      end

      ST_HEAD: begin
        // Build the no-fault, single or announce frame
        total_nxt = total_w;
        base_nxt  = '0;
        seq_nxt   = '0;
        priority if (count_r == 5'd0) begin
          out_kind_nxt = KIND_SINGLE;
          out_last_nxt = 1'b1;
          out_b_nxt[0] = LAMP_NONE;
          out_b_nxt[1] = PAD_BYTE;
          out_b_nxt[2] = 8'h00;
          out_b_nxt[3] = 8'h00;
          out_b_nxt[4] = 8'h00;
          out_b_nxt[5] = 8'h00;
          out_b_nxt[6] = PAD_BYTE;
          out_b_nxt[7] = PAD_BYTE;
        end else if (count_r == 5'd1) begin
          out_kind_nxt = KIND_SINGLE;
          out_last_nxt = 1'b1;
          out_b_nxt[0] = is_red(first_r) ? LAMP_RED : LAMP_AMBER;
          out_b_nxt[1] = PAD_BYTE;
          out_b_nxt[2] = rec_first[7:0];
          out_b_nxt[3] = rec_first[15:8];
          out_b_nxt[4] = rec_first[23:16];
          out_b_nxt[5] = rec_first[31:24];
          out_b_nxt[6] = PAD_BYTE;
          out_b_nxt[7] = PAD_BYTE;
        end else begin
          out_kind_nxt = KIND_ANNOUNCE;
          out_last_nxt = 1'b0;
          out_b_nxt[0] = BAM_CTRL;
          out_b_nxt[1] = {1'b0, total_w};
          out_b_nxt[2] = 8'h00;
          out_b_nxt[3] = {4'h0, bam_packets(total_w)};
          out_b_nxt[4] = PAD_BYTE;
          out_b_nxt[5] = PGN_LO;
          out_b_nxt[6] = PGN_MID;
          out_b_nxt[7] = 8'h00;
        end
        state_nxt = ST_SEND;
      end

      ST_SEND: begin
        // Hold the frame until transfer, then finish or start the next one
        if (out_chan.ready) begin
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            if (out_kind_r == KIND_DATA) begin
              base_nxt = base_end;
            end
            seq_nxt      = seq_r + 4'd1;
            out_b_nxt[0] = {4'h0, seq_r + 4'd1};
            j_nxt        = '0;
            state_nxt    = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        // Drop each returned byte into its lane
        if (rd_vld_r) begin
          out_b_nxt[3'(rd_pos_r + 3'd1)] = byte_w;
        end
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd7) begin
          out_kind_nxt = KIND_DATA;
          out_last_nxt = (base_end >= total_r);
          state_nxt    = ST_SEND;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      seq_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      seq_r    <= seq_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    scan_r     <= scan_nxt;
    first_r    <= first_nxt;
    red_r      <= red_nxt;
    total_r    <= total_nxt;
    base_r     <= base_nxt;
    j_r        <= j_nxt;
    rd_src_r   <= rd_src_nxt;
    rd_sel_r   <= rd_sel_nxt;
    rd_pos_r   <= rd_pos_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    for (int b = 0; b < 8; b++) begin
      out_b_r[b] <= out_b_nxt[b];
    end
  end

  // Report memory: write during scan, registered read during fill
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= fault_record(scan_r);
    end
    mem_q_r <= mem[rd_addr];
  end

  // Ports
  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = (state_r == ST_SEND);
  assign out_chan.frame_kind = out_kind_r;
  assign out_chan.byte0      = out_b_r[0];
  assign out_chan.byte1      = out_b_r[1];
  assign out_chan.byte2      = out_b_r[2];
  assign out_chan.byte3      = out_b_r[3];
  assign out_chan.byte4      = out_b_r[4];
  assign out_chan.byte5      = out_b_r[5];
  assign out_chan.byte6      = out_b_r[6];
  assign out_chan.byte7      = out_b_r[7];
  assign out_chan.last_frame = out_last_r;

  // Checks
  `DM1FRM_ASSERT_IMP(a_no_take_while_sending, out_chan.valid, !in_chan.ready)
  `DM1FRM_ASSERT_IMP(a_count_in_table, state_r == ST_HEAD, count_r <= 5'(LIVE))
  `DM1FRM_ASSERT_NXT(a_last_ends_run, out_chan.valid && out_chan.ready && out_last_r, state_r == ST_IDLE)
  `DM1FRM_ASSERT_IMP(a_fill_numbered, state_r == ST_FILL, seq_r != 4'd0 && count_r >= 5'd2)

endmodule

`default_nettype wire

>>> dv/dm1_fault_report_framer_tb.sv
// Self-checking testbench for the DM1 fault report framer: directed and random
// fault masks, frames predicted in-bench and checked in order. Uses dm1frm_pkg,
// the dm1frm_if channel interfaces and the dm1_fault_report_framer top level.
`timescale 1ns / 1ps

module dm1_fault_report_framer_tb;
  import dm1frm_pkg::*;

  localparam int LIVE_ENTRIES = (TABLE_ENTRIES_DEF > FIXED_ENTRIES) ?
                                FIXED_ENTRIES : TABLE_ENTRIES_DEF;
  localparam int MSG_BYTES    = 98;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLDOFF_LEN  = 400;
  localparam int HOLDOFF_AT   = 40;
  localparam int SETTLE_LEN   = 300;
  localparam int RANDOM_ITEMS = 360;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0][7:0] bytes;
    logic            last;
  } dm1_frame_t;

  typedef struct {
    logic [31:0] mask;
    idle_mode_t  mode;
    bit          drain;
  } mask_req_t;

  logic clk;
  logic rst_n;

  dm1frm_in_if  in_chan ();
  dm1frm_out_if out_chan ();

  dm1_fault_report_framer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Fault table as the report format defines it
  logic [15:0] spn_tab [FIXED_ENTRIES] = '{
    16'h1388, 16'h138A, 16'h138D, 16'h138E, 16'h1390, 16'h1391, 16'h1393, 16'h1394,
    16'h13BA, 16'h13BB, 16'h13BC, 16'h13BD, 16'h13BE, 16'h13BE, 16'h13BE, 16'h13BF,
    16'h13BF, 16'h13BF, 16'h13C0, 16'h13C0, 16'h13C0, 16'h13C1, 16'h13C1, 16'h13C1
  };
  logic [4:0] fmi_tab [FIXED_ENTRIES] = '{
    5'h9, 5'hD, 5'h5, 5'h6, 5'h5, 5'h6, 5'h5, 5'h6,
    5'h6, 5'h2, 5'h6, 5'h6, 5'h6, 5'h9, 5'h2, 5'h6,
    5'h9, 5'h2, 5'h6, 5'h9, 5'h2, 5'h6, 5'h9, 5'h2
  };

  mask_req_t  mask_reqs [$];
  dm1_frame_t frames_due [$];
  idle_mode_t idle_mode;
  int         frame_errors;
  int         masks_taken;
  int         cycle_count;
  bit         in_took;
  int         holdoff_left;
  bit         holdoff_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one expected frame
  function automatic void push_frame(input logic [1:0] kind, input logic [7:0] fb [8],
                                     input logic last);
    dm1_frame_t fr;
    fr.kind = kind;
    for (int j = 0; j < 8; j++) fr.bytes[j] = fb[j];
    fr.last = last;
    frames_due.push_back(fr);
  endfunction

  // Expected frames for one fault mask
  function automatic void queue_dm1_frames(input logic [31:0] mask);
    logic [7:0] fb [8];
    logic [7:0] msg [MSG_BYTES];
    int         faults;
    int         first;
    int         pos;
    int         total;
    int         packets;
    logic       red;
    if (mask == '0) return;
    faults = 0;
    first  = 0;
    red    = 1'b0;
    for (int e = 0; e < LIVE_ENTRIES; e++) begin
      if (mask[e]) begin
        if (faults == 0) first = e;
        faults++;
        if (spn_tab[e] == SPN_RED_A || spn_tab[e] == SPN_RED_B) red = 1'b1;
      end
    end
    // No listed fault: the no-fault frame
    if (faults == 0) begin
      fb = '{LAMP_NONE, PAD_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, PAD_BYTE, PAD_BYTE};
      push_frame(KIND_SINGLE, fb, 1'b1);
      return;
    end
    // One fault: single report; SPNs fit in 16 bits, so code bits 18:16 are zero
    if (faults == 1) begin
      fb = '{red ? LAMP_RED : LAMP_AMBER, PAD_BYTE, spn_tab[first][7:0],
             spn_tab[first][15:8], {3'b000, fmi_tab[first]}, OCC_ONE, PAD_BYTE, PAD_BYTE};
      push_frame(KIND_SINGLE, fb, 1'b1);
      return;
    end
    // Several faults: assemble the message, then announce and data frames
    for (int i = 0; i < MSG_BYTES; i++) msg[i] = PAD_BYTE;
    msg[0] = red ? LAMP_RED : LAMP_AMBER;
    pos = 2;
    for (int e = 0; e < LIVE_ENTRIES; e++) begin
      if (mask[e]) begin
        msg[pos]     = spn_tab[e][7:0];
        msg[pos + 1] = spn_tab[e][15:8];
        msg[pos + 2] = {3'b000, fmi_tab[e]};
        msg[pos + 3] = OCC_ONE;
        pos += 4;
      end
    end
    total   = faults * 4 + 2;
    packets = (total + 6) / 7;
    fb = '{BAM_CTRL, total[7:0], total[15:8], packets[7:0], PAD_BYTE, PGN_LO, PGN_MID,
           8'h00};
    push_frame(KIND_ANNOUNCE, fb, 1'b0);
    for (int k = 1; k <= packets; k++) begin
      fb[0] = k[7:0];
      for (int j = 0; j < 7; j++) begin
        pos       = (k - 1) * 7 + j;
        fb[1 + j] = (pos < MSG_BYTES) ? msg[pos] : PAD_BYTE;
      end
      push_frame(KIND_DATA, fb, (k == packets));
    end
  endfunction

  // Fill the stimulus queue and wait for the end of the run
  initial begin
    logic [31:0] directed [] = '{
      32'h0000_0000, 32'hFF00_0000, 32'h0100_0000, 32'h8000_0000,
      32'h0000_0001, 32'h0000_0002, 32'h0080_0000, 32'hFF00_0001,
      32'h0000_0003, 32'h0000_0006, 32'h00C0_0000, 32'h0000_0007,
      32'h0000_001F, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h00AA_AAAA,
      32'h0055_5555, 32'h0080_0001
    };
    mask_req_t   req;
    int          pick;
    int          n;
    logic [31:0] m;

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.fault_mask   = '0;
    out_chan.ready       = 1'b0;
    idle_mode            = IDLE_NONE;
    frame_errors         = 0;
    masks_taken          = 0;
    cycle_count          = 0;
    in_took              = 1'b0;
    holdoff_left         = 0;
    holdoff_done         = 1'b0;

    foreach (directed[i]) begin
      req.mask  = directed[i];
      req.mode  = IDLE_NONE;
      req.drain = 1'b0;
      mask_reqs.push_back(req);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      m    = '0;
      if (pick < 6) begin
        m = '0;
      end else if (pick < 12) begin
        m = {8'($urandom_range(1, 255)), 24'h0};
      end else if (pick < 30) begin
        m = (32'h1 << $urandom_range(0, LIVE_ENTRIES - 1)) | {8'($urandom), 24'h0};
      end else if (pick < 45) begin
        n = $urandom_range(2, 4);
        for (int b = 0; b < n; b++) m |= 32'h1 << $urandom_range(0, LIVE_ENTRIES - 1);
        m |= {8'($urandom), 24'h0};
      end else begin
        case ($urandom_range(2))
          0: m = $urandom & $urandom;
          1: m = $urandom;
          default: m = $urandom | $urandom;
        endcase
      end
      req.mask = m;
      if (i < 90) req.mode = IDLE_NONE;
      else if (i < 180) req.mode = IDLE_SRC;
      else if (i < 270) req.mode = IDLE_SNK;
      else if (i < 330) req.mode = IDLE_BOTH;
      else req.mode = IDLE_NONE;
      req.drain = (i == 0 || i == 90 || i == 180 || i == 270 || i == 330);
      mask_reqs.push_back(req);
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (mask_reqs.size() != 0 || in_chan.valid) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    if (frame_errors == 0) begin
      $display("dm1_fault_report_framer regression: pass");
    end else begin
      $display("dm1_fault_report_framer regression: fail");
    end
    $finish;
  end

  // Mask driver: hold until transfer, optional gap, pause for drain
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && !in_took) begin
        // hold the offered mask
      end else if (mask_reqs.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (mask_reqs[0].drain && frames_due.size() != 0) begin
        in_chan.valid <= 1'b0;
      end else if ((mask_reqs[0].mode == IDLE_SRC || mask_reqs[0].mode == IDLE_BOTH) &&
                   ($urandom_range(99) < (mask_reqs[0].mode == IDLE_SRC ? 72 : 13))) begin
        in_chan.valid <= 1'b0;
      end else begin
        in_chan.valid      <= 1'b1;
        in_chan.fault_mask <= mask_reqs[0].mask;
        idle_mode          <= mask_reqs[0].mode;
        mask_reqs[0].drain  = 1'b0;
        void'(mask_reqs.pop_front());
      end
    end
  end

  // Frame receiver: random stalls, one long hold-off while masks keep coming
  always @(negedge clk) begin
    if (rst_n) begin
      if (holdoff_left > 0) begin
        out_chan.ready <= 1'b0;
        holdoff_left   <= holdoff_left - 1;
      end else if (!holdoff_done && masks_taken >= HOLDOFF_AT) begin
        out_chan.ready <= 1'b0;
        holdoff_left   <= HOLDOFF_LEN;
        holdoff_done   <= 1'b1;
      end else if (idle_mode == IDLE_SNK) begin
        out_chan.ready <= ($urandom_range(99) >= 72);
      end else if (idle_mode == IDLE_BOTH) begin
        out_chan.ready <= ($urandom_range(99) >= 13);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on mask transfer, check each frame transfer
  always @(posedge clk) begin : monitor
    dm1_frame_t got;
    dm1_frame_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
      $display("dm1_fault_report_framer regression: fail");
      $finish;
    end else if (rst_n) begin
      in_took <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        queue_dm1_frames(in_chan.fault_mask);
        masks_taken++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.kind  = out_chan.frame_kind;
        got.bytes = {out_chan.byte7, out_chan.byte6, out_chan.byte5, out_chan.byte4,
                     out_chan.byte3, out_chan.byte2, out_chan.byte1, out_chan.byte0};
        got.last  = out_chan.last_frame;
        if (frames_due.size() == 0) begin
          frame_errors++;
          $display("%0t: unexpected frame: expected none, got kind %0d bytes %h last %0d",
                   $realtime, got.kind, got.bytes, got.last);
        end else begin
          want = frames_due.pop_front();
          if (got.kind !== want.kind) begin
            frame_errors++;
            $display("%0t: frame_kind expected %0d got %0d", $realtime, want.kind, got.kind);
          end
          for (int j = 0; j < 8; j++) begin
            if (got.bytes[j] !== want.bytes[j]) begin
              frame_errors++;
              $display("%0t: byte%0d expected %h got %h", $realtime, j, want.bytes[j],
                       got.bytes[j]);
            end
          end
          if (got.last !== want.last) begin
            frame_errors++;
            $display("%0t: last_frame expected %0d got %0d", $realtime, want.last,
                     got.last);
          end
        end
      end
    end
  end

endmodule

>>> sim.f
+incdir+design
design/dm1frm_pkg.sv
design/dm1frm_if.sv
design/dm1_fault_report_framer.sv
dv/dm1_fault_report_framer_tb.sv
